@@ rtl/cpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types and constants for the palette color match and pack block.
// ----------------------------------------------------------------------------
package cpm_pkg;

  // Palette depth and the width of an entry address.
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 10;  // three channel differences, at most 765
  localparam int DIST_W  = 8;   // sum / 3, at most 255

  // floor(s / 3) == (s * 683) >> 11 for every s up to 765.
  localparam int RECIP3_W     = 10;
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  // Configuration register indexes.
  localparam logic CFG_PALETTED = 1'b0;
  localparam logic CFG_DEPTH    = 1'b1;

  // Request function codes.
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Output depth codes.
  localparam logic [1:0] DEPTH_8BPP  = 2'd0;
  localparam logic [1:0] DEPTH_16BPP = 2'd1;
  localparam logic [1:0] DEPTH_24BPP = 2'd2;
  localparam logic [1:0] DEPTH_15BPP = 2'd3;

  localparam logic [1:0] DEPTH_RESET = DEPTH_24BPP;

  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] rgb_value;
  } cpm_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               depth_error;
  } cpm_rsp_t;

  // Control from the sequencer to the match unit.
  typedef struct packed {
    logic             clear;  // restart the best-match search
    logic             vld;    // palette read data valid this cycle
    logic [IDX_W-1:0] idx;    // entry address of that data
  } cpm_scan_ctl_t;

endpackage

@@ rtl/cpm_palette_ram.sv @@
// ----------------------------------------------------------------------------
// cpm_palette_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpm_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cpm_match.sv @@
// ----------------------------------------------------------------------------
// cpm_match
// Two-stage distance unit and best-entry tracker fed by the palette RAM.
// ----------------------------------------------------------------------------
module cpm_match (
  input  logic                         clk,
  input  logic                         rst,
  input  cpm_pkg::cpm_scan_ctl_t       ctl,
  input  logic [cpm_pkg::COLOR_W-1:0]  target,
  input  logic [cpm_pkg::COLOR_W-1:0]  entry,
  output logic                         pending,
  output logic [cpm_pkg::IDX_W-1:0]    best_idx,
  output logic [cpm_pkg::COLOR_W-1:0]  best_col
);

  localparam int CW   = cpm_pkg::CHAN_W;
  localparam int PW   = cpm_pkg::SUM_W + cpm_pkg::RECIP3_W;
  // Sentinel above any distance, so entry 0 always takes the lead.
  localparam logic [cpm_pkg::DIST_W:0] DIST_NONE = {1'b1, {cpm_pkg::DIST_W{1'b0}}};

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Stage 1: sum of absolute channel differences.
  logic                          s1_vld;
  logic [cpm_pkg::SUM_W-1:0]     s1_sum;
  logic [cpm_pkg::IDX_W-1:0]     s1_idx;
  logic [cpm_pkg::COLOR_W-1:0]   s1_col;
  logic [cpm_pkg::SUM_W-1:0]     sum_next;

  // Stage 2: divide by three and compare.
  logic [PW-1:0]                 prod;
  logic [cpm_pkg::DIST_W-1:0]    entry_dist;
  logic [cpm_pkg::DIST_W:0]      best_d;

  assign sum_next = cpm_pkg::SUM_W'(abs_diff(target[23:16], entry[23:16]))
                  + cpm_pkg::SUM_W'(abs_diff(target[15:8],  entry[15:8]))
                  + cpm_pkg::SUM_W'(abs_diff(target[7:0],   entry[7:0]));

  assign prod       = PW'(s1_sum) * PW'(cpm_pkg::RECIP3);
  assign entry_dist = prod[cpm_pkg::RECIP3_SHIFT +: cpm_pkg::DIST_W];

  assign pending = ctl.vld | s1_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ctl.vld;
    end
    if (ctl.vld) begin
      s1_sum <= sum_next;
      s1_idx <= ctl.idx;
      s1_col <= entry;
    end
  end

  // Strictly smaller only: earlier entries win ties.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best_d <= DIST_NONE;
    end else if (s1_vld && ({1'b0, entry_dist} < best_d)) begin
      best_d   <= {1'b0, entry_dist};
      best_idx <= s1_idx;
      best_col <= s1_col;
    end
  end

endmodule

@@ rtl/palette_color_match_pack.sv @@
// ----------------------------------------------------------------------------
// palette_color_match_pack
// Converts a 24-bit RGB color to a pixel value, optionally snapping it first
// to the nearest palette entry (Manhattan distance / 3, earliest entry wins).
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  request   in         start & !busy        req (func, entry_index, rgb)
//  result    out        done (one cycle)     rsp (pixel_value, depth_error)
//  config    in         cfg_we               cfg_index, cfg_data
//
//  A palette write or a direct (non-paletted) conversion returns its result
//  in the cycle after the request; busy stays low, so a request per cycle works.
//  A paletted conversion streams all PALETTE_ENTRIES entries out of the
//  palette RAM, one read per cycle, through a two-stage distance unit, and
//  returns the result once the last entry has left that unit. The single RAM
//  read port sets the read pace. busy holds off requests meanwhile, so palette
//  writes never meet an active scan.
//  Synchronous reset clears the sequencer and the configuration registers
//  (paletted_mode 0, depth_mode 24bpp); palette contents are not cleared.
//  Results cannot be stalled: done marks rsp for exactly one cycle.
// ----------------------------------------------------------------------------
module palette_color_match_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cpm_pkg::cpm_req_t req,
  output logic              done,
  output cpm_pkg::cpm_rsp_t rsp,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data
);

  localparam int IDX_W = cpm_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(cpm_pkg::PALETTE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic       paletted_mode;
  logic [1:0] depth_mode;

  // Scan control.
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_vld;
  logic [cpm_pkg::COLOR_W-1:0] target;

  logic                        accept;
  logic                        wr_in_range;
  logic                        ram_we;
  logic                        ram_re;
  logic [cpm_pkg::COLOR_W-1:0] ram_rdata;

  cpm_pkg::cpm_scan_ctl_t      scan_ctl;
  logic                        match_pending;
  logic [IDX_W-1:0]            best_idx;
  logic [cpm_pkg::COLOR_W-1:0] best_col;

  // Form the pixel from a color by depth mode; flag depths that cannot be
  // produced (15bpp, or an 8bpp index without a palette).
  function automatic cpm_pkg::cpm_rsp_t pack_pixel(
    input logic [cpm_pkg::COLOR_W-1:0] color,
    input logic [IDX_W-1:0]            idx,
    input logic                        pal,
    input logic [1:0]                  depth
  );
    cpm_pkg::cpm_rsp_t res;
    res = '0;
    unique case (depth)
      cpm_pkg::DEPTH_8BPP: begin
        if (pal) begin
          res.pixel_value = cpm_pkg::COLOR_W'(idx);
        end else begin
          res.depth_error = 1'b1;
        end
      end
      cpm_pkg::DEPTH_16BPP: begin
        res.pixel_value = {8'd0, color[4:0], color[13:8], color[20:16]};
      end
      cpm_pkg::DEPTH_24BPP: begin
        res.pixel_value = {color[7:0], color[15:8], color[23:16]};
      end
      cpm_pkg::DEPTH_15BPP: begin
        res.depth_error = 1'b1;
      end
    endcase
    return res;
  endfunction

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Drop writes to entries past the end of the palette.
  assign wr_in_range = (32'(req.entry_index) < cpm_pkg::PALETTE_ENTRIES);
  assign ram_we      = accept && (req.func == cpm_pkg::FUNC_WRITE) && wr_in_range;
  assign ram_re      = (state == ST_SCAN);

  assign scan_ctl.clear = accept && (req.func == cpm_pkg::FUNC_CONVERT) && paletted_mode;
  assign scan_ctl.vld   = rd_vld;
  assign scan_ctl.idx   = rd_idx;

  cpm_palette_ram #(
    .DEPTH (cpm_pkg::PALETTE_ENTRIES),
    .WIDTH (cpm_pkg::COLOR_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(req.entry_index)),
    .wdata (req.rgb_value),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  cpm_match u_match (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .target   (target),
    .entry    (ram_rdata),
    .pending  (match_pending),
    .best_idx (best_idx),
    .best_col (best_col)
  );

  // Configuration must be written only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      paletted_mode <= 1'b0;
      depth_mode    <= cpm_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpm_pkg::CFG_PALETTED: paletted_mode <= cfg_data[0];
        cpm_pkg::CFG_DEPTH:    depth_mode    <= cfg_data;
      endcase
    end
  end

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= (state == ST_SCAN);
      rd_idx <= rd_addr;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.func == cpm_pkg::FUNC_WRITE) begin
              done <= 1'b1;
              rsp  <= '0;
            end else if (!paletted_mode) begin
              done <= 1'b1;
              rsp  <= pack_pixel(req.rgb_value, '0, 1'b0, depth_mode);
            end else begin
              // Latch the color and start streaming the palette from entry 0.
              target  <= req.rgb_value;
              rd_addr <= '0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Advance one entry per cycle; the last read leaves for drain.
          if (rd_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end else begin
            rd_addr <= rd_addr + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // Hold until the distance pipeline has retired the last entry.
          if (!rd_vld && !match_pending) begin
            done  <= 1'b1;
            rsp   <= pack_pixel(best_col, best_idx, 1'b1, depth_mode);
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
